FILE: hdl/csvt_pkg.sv
// shared types, codes and constants of the csv byte tokenizer
package csvt_pkg;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  localparam logic [7:0] SepReset          = 8'd44;
  localparam int unsigned MaxColumnsDefault = 65534;

  localparam int unsigned ColW = 16;
  localparam int unsigned RowW = 32;

  typedef enum logic [1:0] {
    KindData     = 2'd0,
    KindFieldEnd = 2'd1,
    KindDone     = 2'd2,
    KindError    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone           = 3'd0,
    ErrEofInQuotes    = 3'd1,
    ErrEmptyLine      = 3'd2,
    ErrTooManyColumns = 3'd3,
    ErrShortRecord    = 3'd4,
    ErrTooManyRows    = 3'd5,
    ErrQuoteAfterQuote = 3'd6,
    ErrUnused         = 3'd7
  } err_e;

  // class of the last thing seen in the current record
  typedef enum logic [1:0] {
    ClassSor  = 2'd0,
    ClassData = 2'd1,
    ClassSep  = 2'd2,
    ClassEndq = 2'd3
  } class_e;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       data_byte;
    logic [ColW-1:0]  column_index;
    logic [RowW-1:0]  row_index;
    logic             record_end;
    err_e             error_code;
    logic             last_of_run;
  } result_t;

  // results produced by one input byte, slot 0 first
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

FILE: hdl/csvt_in_if.sv
// input channel: one csv byte or an end-of-stream mark per transfer
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

FILE: hdl/csvt_out_if.sv
// output channel: one tagged result per transfer
interface csvt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] column_index;
  logic [31:0] row_index;
  logic        record_end;
  logic [2:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output kind, output data_byte, output column_index,
                  output row_index, output record_end, output error_code,
                  output last_of_run, input ready);
  modport sink (input valid, input kind, input data_byte, input column_index,
                input row_index, input record_end, input error_code,
                input last_of_run, output ready);
endinterface

FILE: hdl/csvt_engine.sv
// tokenizer state and the per-byte decision logic
module csvt_engine import csvt_pkg::*; #(
  parameter int unsigned MaxColumns = MaxColumnsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       eos_i,
  input  logic [7:0] sep_i,
  output push_t      push_o
);

  logic            in_quotes_q, in_quotes_d;
  logic            quote_pend_q, quote_pend_d;
  logic            skip_lf_q, skip_lf_d;
  logic            blank_pend_q, blank_pend_d;
  class_e          prev_q, prev_d;
  logic            header_q, header_d;
  logic [ColW-1:0] col_q, col_d;
  logic [ColW-1:0] total_q, total_d;
  logic [RowW-1:0] row_q, row_d;
  logic            halted_q, halted_d;

  logic            go;
  logic [1:0]      n;
  result_t         r0, r1;
  logic [ColW:0]   col_inc;
  logic [ColW:0]   limit;
  logic            is_stop0, is_stop1;

  function automatic result_t mk(kind_e k, logic [7:0] d, logic [ColW-1:0] c,
                                 logic [RowW-1:0] r, logic re, err_e e);
    result_t x;
    x.kind         = k;
    x.data_byte    = d;
    x.column_index = c;
    x.row_index    = r;
    x.record_end   = re;
    x.error_code   = e;
    x.last_of_run  = 1'b0;
    return x;
  endfunction

  assign col_inc = {1'b0, col_q} + {{ColW{1'b0}}, 1'b1};
  assign limit   = header_q ? (ColW+1)'(MaxColumns) : {1'b0, total_q};

  always_comb begin
    in_quotes_d  = in_quotes_q;
    quote_pend_d = quote_pend_q;
    skip_lf_d    = skip_lf_q;
    blank_pend_d = blank_pend_q;
    prev_d       = prev_q;
    header_d     = header_q;
    col_d        = col_q;
    total_d      = total_q;
    row_d        = row_q;
    go           = 1'b0;
    n            = 2'd0;
    r0           = mk(KindData, 8'd0, col_q, row_q, 1'b0, ErrNone);
    r1           = r0;

    if (fire_i && !halted_q) begin
      if (blank_pend_q) begin
        if (eos_i) begin
          r0 = mk(KindDone, 8'd0, col_q, row_q, 1'b0, ErrNone);
          n  = 2'd1;
        end else if (skip_lf_q && byte_i == ChLf) begin
          skip_lf_d = 1'b0;
        end else begin
          skip_lf_d = 1'b0;
          r0 = mk(KindError, 8'd0, col_q, row_q, 1'b0, ErrEmptyLine);
          n  = 2'd1;
        end
      end else begin
        go = 1'b1;
        if (skip_lf_q) begin
          skip_lf_d = 1'b0;
          if (!eos_i && byte_i == ChLf) go = 1'b0;
        end
        // a quote inside quotes is resolved by the byte that follows it
        if (go && quote_pend_q) begin
          quote_pend_d = 1'b0;
          if (!eos_i && byte_i == ChQuote) begin
            r0     = mk(KindData, ChQuote, col_q, row_q, 1'b0, ErrNone);
            n      = 2'd1;
            prev_d = ClassData;
            go     = 1'b0;
          end else begin
            in_quotes_d = 1'b0;
            prev_d      = ClassEndq;
          end
        end

        if (go) begin
          if (header_q && prev_d == ClassSor && col_q == '0 && !in_quotes_d &&
              !eos_i && byte_i[7]) begin
            // leading high byte before the header, dropped
          end else if (in_quotes_d) begin
            if (eos_i) begin
              r0 = mk(KindError, 8'd0, col_q, row_q, 1'b0, ErrEofInQuotes);
              n  = 2'd1;
            end else if (byte_i == ChQuote) begin
              quote_pend_d = 1'b1;
            end else begin
              r0     = mk(KindData, byte_i, col_q, row_q, 1'b0, ErrNone);
              n      = 2'd1;
              prev_d = ClassData;
            end
          end else if (eos_i || byte_i == ChCr || byte_i == ChLf) begin
            if (!eos_i && byte_i == ChCr) skip_lf_d = 1'b1;
            if (prev_d == ClassSor) begin
              if (eos_i) begin
                r0 = mk(KindDone, 8'd0, col_q, row_q, 1'b0, ErrNone);
                n  = 2'd1;
              end else begin
                blank_pend_d = 1'b1;
              end
            end else begin
              r0 = mk(KindFieldEnd, 8'd0, col_q, row_q, 1'b1, ErrNone);
              n  = 2'd1;
              if (header_q) begin
                total_d  = col_inc[ColW-1:0];
                header_d = 1'b0;
                row_d    = RowW'(1);
                col_d    = '0;
                prev_d   = ClassSor;
                if (eos_i) begin
                  r1 = mk(KindDone, 8'd0, '0, RowW'(1), 1'b0, ErrNone);
                  n  = 2'd2;
                end
              end else if (col_inc != {1'b0, total_q}) begin
                r1 = mk(KindError, 8'd0, col_q, row_q, 1'b0, ErrShortRecord);
                n  = 2'd2;
              end else if (row_q == '1) begin
                col_d = '0;
                r1    = mk(KindError, 8'd0, '0, row_q, 1'b0, ErrTooManyRows);
                n     = 2'd2;
              end else begin
                row_d  = row_q + RowW'(1);
                col_d  = '0;
                prev_d = ClassSor;
                if (eos_i) begin
                  r1 = mk(KindDone, 8'd0, '0, row_q + RowW'(1), 1'b0, ErrNone);
                  n  = 2'd2;
                end
              end
            end
          end else if (byte_i == ChQuote) begin
            if (prev_d == ClassEndq) begin
              r0 = mk(KindError, 8'd0, col_q, row_q, 1'b0, ErrQuoteAfterQuote);
              n  = 2'd1;
            end else if (prev_d == ClassData) begin
              r0 = mk(KindData, ChQuote, col_q, row_q, 1'b0, ErrNone);
              n  = 2'd1;
            end else begin
              in_quotes_d = 1'b1;
            end
          end else if (byte_i == sep_i) begin
            r0     = mk(KindFieldEnd, 8'd0, col_q, row_q, 1'b0, ErrNone);
            n      = 2'd1;
            prev_d = ClassSep;
            if (col_inc >= limit) begin
              r1 = mk(KindError, 8'd0, col_q, row_q, 1'b0, ErrTooManyColumns);
              n  = 2'd2;
            end else begin
              col_d = col_inc[ColW-1:0];
            end
          end else begin
            r0     = mk(KindData, byte_i, col_q, row_q, 1'b0, ErrNone);
            n      = 2'd1;
            prev_d = ClassData;
          end
        end
      end
    end

    if (n == 2'd1) r0.last_of_run = 1'b1;
    if (n == 2'd2) r1.last_of_run = 1'b1;
  end

  assign is_stop0 = (n != 2'd0) && (r0.kind == KindDone || r0.kind == KindError);
  assign is_stop1 = (n == 2'd2) && (r1.kind == KindDone || r1.kind == KindError);
  assign halted_d = halted_q | is_stop0 | is_stop1;

  assign push_o.count = n;
  assign push_o.res0  = r0;
  assign push_o.res1  = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quotes_q  <= 1'b0;
      quote_pend_q <= 1'b0;
      skip_lf_q    <= 1'b0;
      blank_pend_q <= 1'b0;
      prev_q       <= ClassSor;
      header_q     <= 1'b1;
      col_q        <= '0;
      total_q      <= '0;
      row_q        <= '0;
      halted_q     <= 1'b0;
    end else begin
      in_quotes_q  <= in_quotes_d;
      quote_pend_q <= quote_pend_d;
      skip_lf_q    <= skip_lf_d;
      blank_pend_q <= blank_pend_d;
      prev_q       <= prev_d;
      header_q     <= header_d;
      col_q        <= col_d;
      total_q      <= total_d;
      row_q        <= row_d;
      halted_q     <= halted_d;
    end
  end

endmodule

FILE: hdl/csvt_result_queue.sv
// four-entry result queue, takes up to two results per cycle and gives one
module csvt_result_queue import csvt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  input  logic    pop_i,
  output logic    valid_o,
  output result_t head_o
);

  result_t    mem_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] cnt_q, cnt_d;

  assign valid_o = cnt_q != 3'd0;
  assign head_o  = mem_q[rd_ptr_q];
  // two free entries are needed before the engine may take a byte
  assign room_o  = cnt_q <= 3'd2;

  assign wr_ptr_d = wr_ptr_q + push_i.count;
  assign rd_ptr_d = rd_ptr_q + {1'b0, pop_i};
  assign cnt_d    = cnt_q + {1'b0, push_i.count} - {2'b0, pop_i};

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.res0;
    if (push_i.count == 2'd2) mem_q[wr_ptr_q + 2'd1] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: hdl/csv_byte_tokenizer_core.sv
// top level of the csv byte tokenizer
//
// in_i carries one csv byte, or an end-of-stream mark, per transfer (valid/ready).
// out_o carries tagged results: field data byte, field end (with record end
// flag), done, or error with a code; last_of_run marks the final result of a byte.
// cfg_we_i/cfg_wdata_i write the separator byte; write it only while idle.
// an accepted byte is held in the input register until the result queue has room,
// then decoded by the engine, and its results are registered in the queue before
// they appear on out_o.
// throughput is one byte per cycle while each byte gives at most one result and out_o
// is not stalled; both results of a byte that gives two are given out in turn by the
// single-result-per-cycle output of the four-entry result queue.
// after done or an error every further byte is accepted and dropped until reset.
// a stall on out_o fills the result queue, then the input register, then
// in_i.ready drops; nothing is lost.
// reset clears all parser state, empties the queue and sets the separator to a comma.
module csv_byte_tokenizer_core import csvt_pkg::*; #(
  parameter int unsigned MaxColumns = MaxColumnsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csvt_in_if.sink    in_i,
  csvt_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_eos_q;
  logic       s1_go;
  logic       in_xfer;
  logic [7:0] sep_q;
  logic       room;
  logic       pop;
  push_t      push;
  result_t    head;

  assign s1_go      = s1_valid_q && room;
  assign in_i.ready = !s1_valid_q || s1_go;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign s1_valid_d = in_xfer || (s1_valid_q && !s1_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      sep_q      <= SepReset;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (cfg_we_i) sep_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= in_i.in_byte;
      s1_eos_q  <= in_i.end_of_stream;
    end
  end

  csvt_engine #(
    .MaxColumns(MaxColumns)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_go),
    .byte_i (s1_byte_q),
    .eos_i  (s1_eos_q),
    .sep_i  (sep_q),
    .push_o (push)
  );

  csvt_result_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .pop_i   (pop),
    .valid_o (out_o.valid),
    .head_o  (head)
  );

  assign pop = out_o.valid && out_o.ready;

  assign out_o.kind         = head.kind;
  assign out_o.data_byte    = head.data_byte;
  assign out_o.column_index = head.column_index;
  assign out_o.row_index    = head.row_index;
  assign out_o.record_end   = head.record_end;
  assign out_o.error_code   = head.error_code;
  assign out_o.last_of_run  = head.last_of_run;

endmodule

FILE: bench/testbench.sv
// self-checking bench for the csv byte tokenizer: a predictor follows the byte stream, results are compared in order
module testbench;
  import csvt_pkg::*;

  localparam int unsigned MaxCols       = MaxColumnsDefault;
  localparam int unsigned HeaderColumns = 3;
  localparam int unsigned PhaseBytes    = 32;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned DrainLimit    = 2000;
  localparam int unsigned ReportLimit   = 10;

  // header, then one data row: skipped high bytes, doubled quote, crlf,
  // separator and lf inside quotes, quote after plain data, lone cr
  localparam logic [7:0] OpeningBytes [23] = '{
    8'h80, 8'hff, 8'h68, SepReset, ChQuote, 8'h78, ChQuote, ChQuote, ChQuote,
    SepReset, ChCr, ChLf,
    8'h00, SepReset, ChQuote, 8'hff, SepReset, ChLf, ChQuote, SepReset, 8'h61,
    ChQuote, ChCr
  };

  typedef enum logic [1:0] {
    Running     = 2'd0,
    HaltedDone  = 2'd1,
    HaltedError = 2'd2
  } halt_e;

  class token_predictor;
    result_t     expected_tokens[$];
    result_t     step_tokens[$];
    int unsigned failures;
    int unsigned checked;
    int unsigned kind_count[4];
    kind_e       last_kind;
    err_e        last_err;
    int unsigned max_cols;

    logic [7:0]  separator;
    logic        in_quotes, quote_pending, skip_lf, blank_pending, header_phase;
    class_e      prev_class;
    logic [15:0] col_cnt, col_total;
    logic [31:0] row_cnt;
    halt_e       halted;

    function new(int unsigned mc);
      max_cols      = mc;
      separator     = SepReset;
      in_quotes     = 1'b0;
      quote_pending = 1'b0;
      skip_lf       = 1'b0;
      blank_pending = 1'b0;
      header_phase  = 1'b1;
      prev_class    = ClassSor;
      col_cnt       = '0;
      col_total     = '0;
      row_cnt       = '0;
      halted        = Running;
      failures      = 0;
      checked       = 0;
      last_kind     = KindData;
      last_err      = ErrNone;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction

    function void emit(kind_e k, logic [7:0] d, logic rec_end, err_e e);
      result_t r;
      r.kind         = k;
      r.data_byte    = d;
      r.column_index = col_cnt;
      r.row_index    = row_cnt;
      r.record_end   = rec_end;
      r.error_code   = e;
      r.last_of_run  = 1'b0;
      step_tokens = {step_tokens, r};
      if (k == KindDone) halted = HaltedDone;
      if (k == KindError) halted = HaltedError;
    endfunction

    function void parse_byte(logic [7:0] c, logic eos);
      int unsigned lim;
      if (header_phase && prev_class == ClassSor && col_cnt == 0 && !in_quotes && !eos && c[7])
        return;
      if (in_quotes) begin
        if (eos) begin
          emit(KindError, 8'h00, 1'b0, ErrEofInQuotes);
          return;
        end
        if (c == ChQuote) begin
          quote_pending = 1'b1;
          return;
        end
        emit(KindData, c, 1'b0, ErrNone);
        prev_class = ClassData;
        return;
      end
      if (eos || c == ChCr || c == ChLf) begin
        if (!eos && c == ChCr) skip_lf = 1'b1;
        if (prev_class == ClassSor) begin
          if (eos) emit(KindDone, 8'h00, 1'b0, ErrNone);
          else blank_pending = 1'b1;
          return;
        end
        emit(KindFieldEnd, 8'h00, 1'b1, ErrNone);
        if (header_phase) begin
          col_total    = col_cnt + 16'd1;
          header_phase = 1'b0;
          row_cnt      = 32'd1;
        end else begin
          if (int'(col_cnt) + 1 != int'(col_total)) begin
            emit(KindError, 8'h00, 1'b0, ErrShortRecord);
            return;
          end
          if (row_cnt == '1) begin
            col_cnt = '0;
            emit(KindError, 8'h00, 1'b0, ErrTooManyRows);
            return;
          end
          row_cnt++;
        end
        col_cnt    = '0;
        prev_class = ClassSor;
        if (eos) emit(KindDone, 8'h00, 1'b0, ErrNone);
        return;
      end
      if (c == ChQuote) begin
        if (prev_class == ClassEndq) emit(KindError, 8'h00, 1'b0, ErrQuoteAfterQuote);
        else if (prev_class == ClassData) emit(KindData, c, 1'b0, ErrNone);
        else in_quotes = 1'b1;
        return;
      end
      if (c == separator) begin
        lim = header_phase ? max_cols : int'(col_total);
        emit(KindFieldEnd, 8'h00, 1'b0, ErrNone);
        prev_class = ClassSep;
        if (int'(col_cnt) + 1 >= lim) begin
          emit(KindError, 8'h00, 1'b0, ErrTooManyColumns);
          return;
        end
        col_cnt++;
        return;
      end
      emit(KindData, c, 1'b0, ErrNone);
      prev_class = ClassData;
    endfunction

    // called once per accepted input transfer
    function void note_byte(logic [7:0] c, logic eos);
      logic    go;
      result_t r;
      step_tokens.delete();
      if (halted != Running) return;
      if (blank_pending) begin
        if (eos) begin
          emit(KindDone, 8'h00, 1'b0, ErrNone);
        end else if (skip_lf && c == ChLf) begin
          skip_lf = 1'b0;
        end else begin
          skip_lf = 1'b0;
          emit(KindError, 8'h00, 1'b0, ErrEmptyLine);
        end
      end else begin
        go = 1'b1;
        if (skip_lf) begin
          skip_lf = 1'b0;
          if (!eos && c == ChLf) go = 1'b0;
        end
        if (go && quote_pending) begin
          quote_pending = 1'b0;
          if (!eos && c == ChQuote) begin
            emit(KindData, c, 1'b0, ErrNone);
            prev_class = ClassData;
            go = 1'b0;
          end else begin
            in_quotes  = 1'b0;
            prev_class = ClassEndq;
          end
        end
        if (go) parse_byte(c, eos);
      end
      if (step_tokens.size() > 0) begin
        r = step_tokens[step_tokens.size() - 1];
        r.last_of_run = 1'b1;
        step_tokens[step_tokens.size() - 1] = r;
      end
      expected_tokens = {expected_tokens, step_tokens};
    endfunction

    function string show(result_t r);
      return $sformatf("kind=%0d data=%02h col=%0d row=%0d rec_end=%0b err=%0d last=%0b",
                       r.kind, r.data_byte, r.column_index, r.row_index, r.record_end,
                       r.error_code, r.last_of_run);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= ReportLimit) $display("mismatch: %s", msg);
    endfunction

    function void check_token(result_t got);
      result_t exp;
      string   bad;
      if (expected_tokens.size() == 0) begin
        flag($sformatf("unexpected result %s", show(got)));
        return;
      end
      exp = expected_tokens.pop_front();
      bad = "";
      if (got.kind !== exp.kind) bad = {bad, " kind"};
      if (got.data_byte !== exp.data_byte) bad = {bad, " data_byte"};
      if (got.column_index !== exp.column_index) bad = {bad, " column_index"};
      if (got.row_index !== exp.row_index) bad = {bad, " row_index"};
      if (got.record_end !== exp.record_end) bad = {bad, " record_end"};
      if (got.error_code !== exp.error_code) bad = {bad, " error_code"};
      if (got.last_of_run !== exp.last_of_run) bad = {bad, " last_of_run"};
      if (bad != "")
        flag($sformatf("%s differ, expected %s, got %s", bad, show(exp), show(got)));
      checked++;
      kind_count[int'(exp.kind)]++;
      last_kind = exp.kind;
      last_err  = exp.error_code;
    endfunction

    function void flag_leftovers();
      foreach (expected_tokens[i]) flag($sformatf("missing result %s", show(expected_tokens[i])));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic [7:0]  cur_sep = SepReset;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  token_predictor tokens = new(MaxCols);

  csvt_in_if  in_ch();
  csvt_out_if out_ch();

  csv_byte_tokenizer_core #(
    .MaxColumns(MaxCols)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver side: random back-pressure on the result channel
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_monitor
    result_t got;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind         = kind_e'(out_ch.kind);
        got.data_byte    = out_ch.data_byte;
        got.column_index = out_ch.column_index;
        got.row_index    = out_ch.row_index;
        got.record_end   = out_ch.record_end;
        got.error_code   = err_e'(out_ch.error_code);
        got.last_of_run  = out_ch.last_of_run;
        tokens.check_token(got);
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no transfer for %0d cycles", QuietLimit);
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  function automatic logic [7:0] plain_byte(input bit allow_quote);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ChCr || b == ChLf || b == cur_sep || (b == ChQuote && !allow_quote));
    return b;
  endfunction

  function automatic logic [7:0] quoted_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ChQuote);
    return b;
  endfunction

  function automatic logic [7:0] any_separator();
    logic [7:0] s;
    do s = 8'($urandom_range(0, 255));
    while (s == ChQuote || s == ChCr || s == ChLf);
    return s;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.end_of_stream <= eos;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    tokens.note_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tokens.pending() != 0) @(posedge clk_i);
    // bytes that give no result may still sit in the pipeline
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_separator(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    tokens.separator = v;
    cur_sep = v;
  endtask

  task automatic send_field(input bit lone);
    int unsigned style, len;
    style = $urandom_range(0, 5);
    if (style == 0 && !lone) return;
    if (style <= 2) begin
      len = $urandom_range(1, 4);
      send_item(plain_byte(1'b0), 1'b0);
      repeat (len - 1) send_item(plain_byte(1'b1), 1'b0);
    end else begin
      send_item(ChQuote, 1'b0);
      len = $urandom_range(0, 4);
      repeat (len) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(ChQuote, 1'b0);
          send_item(ChQuote, 1'b0);
        end else begin
          send_item(quoted_byte(), 1'b0);
        end
      end
      send_item(ChQuote, 1'b0);
    end
  endtask

  task automatic send_record();
    for (int col = 0; col < HeaderColumns; col++) begin
      send_field(HeaderColumns == 1);
      if (col < HeaderColumns - 1) send_item(cur_sep, 1'b0);
    end
    case ($urandom_range(0, 2))
      0: send_item(ChLf, 1'b0);
      1: send_item(ChCr, 1'b0);
      default: begin
        send_item(ChCr, 1'b0);
        send_item(ChLf, 1'b0);
      end
    endcase
  endtask

  task automatic run_phase(input logic [7:0] sep, input int unsigned s_idle,
                           input int unsigned r_stall);
    int unsigned start;
    pause_until_drained();
    write_separator(sep);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    start = bytes_sent;
    while (bytes_sent - start < PhaseBytes) send_record();
  endtask

  // one way of ending the stream, then bytes that must be dropped
  task automatic run_tail();
    int unsigned pick;
    pause_until_drained();
    pick = $urandom_range(0, 9);
    case (pick)
      0: ;
      1: send_item(ChLf, 1'b0);
      2: begin
        send_item(ChLf, 1'b0);
        send_item(plain_byte(1'b0), 1'b0);
      end
      3: begin
        send_item(ChQuote, 1'b0);
        send_item(quoted_byte(), 1'b0);
      end
      4: repeat (HeaderColumns) begin
        send_item(plain_byte(1'b0), 1'b0);
        send_item(cur_sep, 1'b0);
      end
      5: begin
        send_item(plain_byte(1'b0), 1'b0);
        send_item(ChCr, 1'b0);
      end
      6: for (int col = 0; col < HeaderColumns; col++) begin
        send_item(plain_byte(1'b0), 1'b0);
        if (col < HeaderColumns - 1) send_item(cur_sep, 1'b0);
      end
      default: begin
        // separator collides with a quote or a line end, then raw noise
        case ($urandom_range(0, 2))
          0: write_separator(ChQuote);
          1: write_separator(ChCr);
          default: write_separator(ChLf);
        endcase
        repeat (30) begin
          if (tokens.halted == Running)
            send_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
      end
    endcase
    send_item(8'($urandom_range(0, 255)), 1'b1);
    repeat (3) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned drain_wait;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = 8'h00;
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = 8'h00;
    in_ch.end_of_stream = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (OpeningBytes[i]) send_item(OpeningBytes[i], 1'b0);

    run_phase(8'h00, 79, 0);
    run_phase(8'hff, 0, 79);
    run_phase(any_separator(), 32, 32);
    run_phase(any_separator(), 0, 0);
    run_tail();

    in_ch.valid <= 1'b0;
    drain_wait = 0;
    while (tokens.pending() != 0 && drain_wait < DrainLimit) begin
      @(posedge clk_i);
      drain_wait++;
    end
    tokens.flag_leftovers();
    repeat (SettleCycles) @(posedge clk_i);

    $display("run: %0d bytes over five separator settings, %0d results checked", bytes_sent,
             tokens.checked);
    $display("run: %0d data, %0d field ends, stream closed by kind %0d code %0d, %0d failures",
             tokens.kind_count[0], tokens.kind_count[1], tokens.last_kind, tokens.last_err,
             tokens.failures);
    if (tokens.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: csv_byte_tokenizer_core.f
hdl/csvt_pkg.sv
hdl/csvt_in_if.sv
hdl/csvt_out_if.sv
hdl/csvt_engine.sv
hdl/csvt_result_queue.sv
hdl/csv_byte_tokenizer_core.sv
bench/testbench.sv
